// File: rtl/core/fxalu_pkg.sv
// Package for the signed Q24.8 fixed-point ALU: opcodes, status codes,
// fraction width and the stage record types. No dependencies.
`default_nettype none

package fxalu_pkg;

    // Number of fractional bits in the raw fixed-point format
    localparam int FRAC_BITS = 8;
    // Quotient width of the exact divide: magnitude shifted left by FRAC_BITS
    localparam int QW = 32 + FRAC_BITS;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_DIV   = 4'd3,
        OP_NEG   = 4'd4,
        OP_INC   = 4'd5,
        OP_DEC   = 4'd6,
        OP_GT    = 4'd7,
        OP_LT    = 4'd8,
        OP_GE    = 4'd9,
        OP_LE    = 4'd10,
        OP_EQ    = 4'd11,
        OP_NE    = 4'd12,
        OP_MIN   = 4'd13,
        OP_MAX   = 4'd14,
        OP_TOINT = 4'd15
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_SAT  = 2'd2
    } status_t;

    // Record carried through the divider stages
    typedef struct packed {
        op_t           op;
        logic          neg;
        logic [31:0]   res;
        logic          cmp;
        status_t       status;
        logic [31:0]   a_mag;
        logic [31:0]   b_mag;
        logic [31:0]   rem;
        logic [QW-1:0] dvd;
    } div_stage_t;

    // Record after the multiply and quotient rounding
    typedef struct packed {
        op_t         op;
        logic        neg;
        logic [31:0] res;
        logic        cmp;
        status_t     status;
        logic [63:0] mag;
    } fin_stage_t;

endpackage

`default_nettype wire

// File: rtl/core/fixed_point_alu_q24_8_top.sv
// Top level of the signed Q24.8 fixed-point ALU pipeline.
// Depends on fxalu_pkg for opcodes, status codes and stage records.
//
// Usage:
//   Slave channel s_tvalid/s_tready/s_tdata carries one operation per
//   transaction: opcode and two raw Q24.8 operands. Master channel
//   m_tvalid/m_tready/m_tdata returns one result per operation, in order.
//   Every operation, simple or not, passes the same QW+3 = 43 register
//   stages: an input decode stage, 40 restoring-divide stages (one quotient
//   bit each), a multiply/round stage and a saturate stage that is also the
//   output register. Throughput is one transaction per cycle while m_tready
//   does not hold the output, set by the one-bit-per-stage divider array.
//   When the output register holds a result that m_tready does not take,
//   the whole pipeline holds and s_tready drops; no transaction is lost or
//   repeated. Asynchronous active-low reset clears all valid bits; the
//   pipeline is empty and ready as soon as reset is released.
`default_nettype none

module fixed_point_alu_q24_8_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // func[3:0], operand_a[35:4], operand_b[67:36], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // result_raw[31:0], compare_true[32], status[34:33], pad
);

    localparam int QW = fxalu_pkg::QW;
    localparam int FB = fxalu_pkg::FRAC_BITS;

    logic advance;

    fxalu_pkg::div_stage_t div_reg [0:QW];
    fxalu_pkg::div_stage_t div_next [1:QW];
    logic [QW:0]           div_vld_reg;

    fxalu_pkg::fin_stage_t fin_reg;
    fxalu_pkg::fin_stage_t fin_next;
    logic                  fin_vld_reg;

    logic [31:0]           out_res_reg, out_res_next;
    logic                  out_cmp_reg, out_cmp_next;
    fxalu_pkg::status_t    out_st_reg, out_st_next;
    logic                  out_vld_reg;

    fxalu_pkg::div_stage_t in_next;

    // Hold every stage while the output register is stuck
    assign advance  = !out_vld_reg || m_tready;
    assign s_tready = advance;

    // Decode the transaction, compute the simple ops and operand magnitudes
    always_comb
    begin
        logic [3:0]  fcode;
        logic [31:0] a;
        logic [31:0] b;
        logic        a_lt_b;
        logic        b_lt_a;
        fcode  = s_tdata[3:0];
        a      = s_tdata[35:4];
        b      = s_tdata[67:36];
        a_lt_b = $signed(a) < $signed(b);
        b_lt_a = $signed(b) < $signed(a);

        in_next.op     = fxalu_pkg::op_t'(fcode);
        in_next.neg    = a[31] ^ b[31];
        in_next.res    = '0;
        in_next.cmp    = 1'b0;
        in_next.status = fxalu_pkg::ST_OK;
        in_next.a_mag  = a[31] ? (32'd0 - a) : a;
        in_next.b_mag  = b[31] ? (32'd0 - b) : b;
        in_next.rem    = '0;
        in_next.dvd    = {in_next.a_mag, {FB{1'b0}}};

        unique case (in_next.op)
            fxalu_pkg::OP_ADD: in_next.res = a + b;
            fxalu_pkg::OP_SUB: in_next.res = a - b;
            fxalu_pkg::OP_MUL: in_next.res = '0;
            fxalu_pkg::OP_DIV:
            begin
                if (b == 32'd0)
                begin
                    in_next.status = fxalu_pkg::ST_DIV0;
                end
            end
            fxalu_pkg::OP_NEG:
            begin
                if (a == 32'h8000_0000)
                begin
                    in_next.res    = 32'h7FFF_FFFF;
                    in_next.status = fxalu_pkg::ST_SAT;
                end
                else
                begin
                    in_next.res = 32'd0 - a;
                end
            end
            fxalu_pkg::OP_INC:   in_next.res = a + 32'd1;
            fxalu_pkg::OP_DEC:   in_next.res = a - 32'd1;
            fxalu_pkg::OP_GT:    in_next.cmp = b_lt_a;
            fxalu_pkg::OP_LT:    in_next.cmp = a_lt_b;
            fxalu_pkg::OP_GE:    in_next.cmp = !a_lt_b;
            fxalu_pkg::OP_LE:    in_next.cmp = !b_lt_a;
            fxalu_pkg::OP_EQ:    in_next.cmp = (a == b);
            fxalu_pkg::OP_NE:    in_next.cmp = (a != b);
            fxalu_pkg::OP_MIN:   in_next.res = a_lt_b ? a : b;
            fxalu_pkg::OP_MAX:   in_next.res = b_lt_a ? a : b;
            fxalu_pkg::OP_TOINT: in_next.res = 32'($signed(a) >>> FB);
            default:             in_next.res = '0;
        endcase
    end

    // One restoring-divide step per stage, quotient bits shift into dvd
    for (genvar k = 1; k <= QW; k++)
    begin : g_div
        always_comb
        begin
            logic [32:0] trial;
            logic        ge;
            trial = {div_reg[k-1].rem, div_reg[k-1].dvd[QW-1]};
            ge    = trial >= {1'b0, div_reg[k-1].b_mag};
            div_next[k]     = div_reg[k-1];
            div_next[k].rem = ge ? 32'(trial - {1'b0, div_reg[k-1].b_mag}) : trial[31:0];
            div_next[k].dvd = {div_reg[k-1].dvd[QW-2:0], ge};
        end
    end

    // Multiply magnitudes, or round the quotient half away from zero
    always_comb
    begin
        logic rnd;
        rnd = {div_reg[QW].rem, 1'b0} >= {1'b0, div_reg[QW].b_mag};
        fin_next.op     = div_reg[QW].op;
        fin_next.neg    = div_reg[QW].neg;
        fin_next.res    = div_reg[QW].res;
        fin_next.cmp    = div_reg[QW].cmp;
        fin_next.status = div_reg[QW].status;
        if (div_reg[QW].op == fxalu_pkg::OP_MUL)
        begin
            fin_next.mag = div_reg[QW].a_mag * div_reg[QW].b_mag;
        end
        else
        begin
            fin_next.mag = 64'(div_reg[QW].dvd) + 64'(rnd);
        end
    end

    // Round the product, then saturate and rebuild the sign
    always_comb
    begin
        logic [63:0] mag;
        logic        wide;
        mag = fin_reg.mag;
        if (fin_reg.op == fxalu_pkg::OP_MUL)
        begin
            mag = (fin_reg.mag + (64'd1 << (FB - 1))) >> FB;
        end
        out_res_next = fin_reg.res;
        out_cmp_next = fin_reg.cmp;
        out_st_next  = fin_reg.status;
        wide = fin_reg.neg ? (mag > 64'h8000_0000) : (mag > 64'h7FFF_FFFF);
        if ((fin_reg.op == fxalu_pkg::OP_MUL || fin_reg.op == fxalu_pkg::OP_DIV)
            && fin_reg.status == fxalu_pkg::ST_OK)
        begin
            if (wide)
            begin
                out_st_next  = fxalu_pkg::ST_SAT;
                out_res_next = fin_reg.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            else
            begin
                out_res_next = fin_reg.neg ? (32'd0 - mag[31:0]) : mag[31:0];
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_vld_reg <= '0;
            fin_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            div_vld_reg <= {div_vld_reg[QW-1:0], s_tvalid};
            fin_vld_reg <= div_vld_reg[QW];
            out_vld_reg <= fin_vld_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            div_reg[0] <= in_next;
            for (int k = 1; k <= QW; k++)
            begin
                div_reg[k] <= div_next[k];
            end
            fin_reg     <= fin_next;
            out_res_reg <= out_res_next;
            out_cmp_reg <= out_cmp_next;
            out_st_reg  <= out_st_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'd0, out_st_reg, out_cmp_reg, out_res_reg};

endmodule

`default_nettype wire
